// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by bblc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check with reset disable.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check with reset disable.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bblc_pkg.sv =====
package bblc_pkg;

  localparam int unsigned Entries = 16;
  localparam int unsigned IdxW = $clog2(Entries);
  localparam int unsigned CntW = $clog2(Entries + 1);
  localparam logic [31:0] BudgetReset = 32'd268435456;

  typedef enum logic [1:0] {
    CMD_ACCESS = 2'd0,
    CMD_EVICT  = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_HIT     = 3'd0,
    ST_LOADED  = 3'd1,
    ST_FAILED  = 3'd2,
    ST_REMOVED = 3'd3,
    ST_ABSENT  = 3'd4,
    ST_CLEARED = 3'd5,
    ST_VICTIM  = 3'd6
  } status_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] key;
    logic [31:0] offset;
    logic [31:0] length;
    logic [31:0] load_size;
    logic        load_ok;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] key_out;
    logic [31:0] object_size;
    logic        in_range;
    logic [36:0] bytes_in_use;
    logic [8:0]  entry_count;
    logic        last;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic        latch;      // capture request
    logic        scan_clr;   // start a scan
    logic        scan_step;  // examine entry idx_q
    logic        hit_touch;  // refresh stamp of found entry
    logic        evict_old;  // drop oldest entry
    logic        evict_hit;  // drop found entry
    logic        insert;     // insert at free slot
    logic        clear;      // drop everything
    logic        emit;       // load output register
    logic [2:0]  status;
    logic        last;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] command;
    logic       load_ok;
    logic       found;
    logic       empty;
    logic       fits;
    logic       scan_done;
  } dp_sts_t;

endpackage

// ===== hw/rtl/bblc_if.sv =====
interface bblc_req_if;
  logic              valid;
  logic              ready;
  bblc_pkg::req_t    payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bblc_rsp_if;
  logic              valid;
  logic              ready;
  bblc_pkg::rsp_t    payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bblc_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/bblc_datapath.sv =====
module bblc_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bblc_pkg::req_t      req_i,
  input  logic [31:0]         budget_i,
  input  bblc_pkg::dp_cmd_t   cmd_i,
  output bblc_pkg::dp_sts_t   sts_o,
  output bblc_pkg::rsp_t      rsp_o
);

  localparam int unsigned N = bblc_pkg::Entries;
  localparam int unsigned IW = bblc_pkg::IdxW;
  localparam int unsigned CW = bblc_pkg::CntW;

  bblc_pkg::req_t req_q;
  logic [31:0] keys_q [N];
  logic [31:0] sizes_q [N];
  logic [63:0] stamps_q [N];
  logic [N-1:0] valid_q;
  logic [36:0] total_q;
  logic [63:0] use_q;
  logic [CW-1:0] count_q;

  // scan state
  logic [CW-1:0] idx_q;
  logic          found_q, old_v_q;
  logic [IW-1:0] found_idx_q, old_idx_q;
  logic [63:0]   old_stamp_q;
  bblc_pkg::rsp_t rsp_q;

  logic [IW-1:0] idx;
  logic [IW-1:0] free_idx;
  logic [31:0]   obj_size;
  logic [32:0]   span;
  logic [37:0]   need;

  assign idx = idx_q[IW-1:0];
  assign span = {1'b0, req_q.offset} + {1'b0, req_q.length};
  assign need = {1'b0, total_q} + {6'd0, req_q.load_size};

  always_comb begin
    free_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_idx = IW'(i);
    end
  end

  assign obj_size = sizes_q[found_idx_q];

  assign sts_o.command   = req_q.command;
  assign sts_o.load_ok   = req_q.load_ok;
  assign sts_o.found     = found_q;
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.fits      = (need <= {6'd0, budget_i}) && (count_q != CW'(N));
  assign sts_o.scan_done = (idx_q == CW'(N));
  assign rsp_o = rsp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) req_q <= req_i;
    if (cmd_i.hit_touch) stamps_q[found_idx_q] <= use_q + 64'd1;
    if (cmd_i.insert) begin
      keys_q[free_idx]   <= req_q.key;
      sizes_q[free_idx]  <= req_q.load_size;
      stamps_q[free_idx] <= use_q + 64'd1;
    end
    if (cmd_i.scan_step && valid_q[idx]) begin
      if (keys_q[idx] == req_q.key && !found_q) found_idx_q <= idx;
      if (!old_v_q || stamps_q[idx] < old_stamp_q) begin
        old_idx_q   <= idx;
        old_stamp_q <= stamps_q[idx];
      end
    end
    if (cmd_i.emit) begin
      rsp_q.status <= cmd_i.status;
      rsp_q.last   <= cmd_i.last;
      rsp_q.in_range <= 1'b0;
      rsp_q.key_out  <= req_q.key;
      rsp_q.object_size <= '0;
      rsp_q.bytes_in_use <= total_q;
      rsp_q.entry_count  <= 9'(count_q);
      case (bblc_pkg::status_e'(cmd_i.status))
        bblc_pkg::ST_HIT: begin
          rsp_q.object_size <= obj_size;
          rsp_q.in_range <= (span <= {1'b0, obj_size});
        end
        bblc_pkg::ST_LOADED: begin
          rsp_q.object_size <= req_q.load_size;
          rsp_q.in_range <= (span <= {1'b0, req_q.load_size});
          rsp_q.bytes_in_use <= need[36:0];
          rsp_q.entry_count <= 9'(count_q + CW'(1));
        end
        bblc_pkg::ST_REMOVED: begin
          rsp_q.object_size <= obj_size;
          rsp_q.bytes_in_use <= total_q - {5'd0, obj_size};
          rsp_q.entry_count <= 9'(count_q - CW'(1));
        end
        bblc_pkg::ST_VICTIM: begin
          rsp_q.key_out <= keys_q[old_idx_q];
          rsp_q.object_size <= sizes_q[old_idx_q];
          rsp_q.bytes_in_use <= total_q - {5'd0, sizes_q[old_idx_q]};
          rsp_q.entry_count <= 9'(count_q - CW'(1));
        end
        bblc_pkg::ST_CLEARED: begin
          rsp_q.key_out <= '0;
          rsp_q.bytes_in_use <= '0;
          rsp_q.entry_count <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      total_q <= '0;
      use_q   <= '0;
      count_q <= '0;
      idx_q   <= '0;
      found_q <= 1'b0;
      old_v_q <= 1'b0;
    end else begin
      if (cmd_i.scan_clr) begin
        idx_q   <= '0;
        found_q <= 1'b0;
        old_v_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        idx_q <= idx_q + CW'(1);
        if (valid_q[idx]) begin
          old_v_q <= 1'b1;
          if (keys_q[idx] == req_q.key) found_q <= 1'b1;
        end
      end
      if (cmd_i.hit_touch) use_q <= use_q + 64'd1;
      if (cmd_i.evict_old) begin
        valid_q[old_idx_q] <= 1'b0;
        total_q <= total_q - {5'd0, sizes_q[old_idx_q]};
        count_q <= count_q - CW'(1);
      end
      if (cmd_i.evict_hit) begin
        valid_q[found_idx_q] <= 1'b0;
        total_q <= total_q - {5'd0, obj_size};
        count_q <= count_q - CW'(1);
      end
      if (cmd_i.insert) begin
        valid_q[free_idx] <= 1'b1;
        total_q <= need[36:0];
        count_q <= count_q + CW'(1);
        use_q   <= use_q + 64'd1;
      end
      if (cmd_i.clear) begin
        valid_q <= '0;
        total_q <= '0;
        count_q <= '0;
      end
    end
  end

endmodule

// ===== hw/rtl/bblc_ctrl.sv =====
module bblc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  input  bblc_pkg::dp_sts_t  sts_i,
  output bblc_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_OLDSCAN, S_VICTIM, S_WAIT
  } state_e;

  state_e state_q, state_d;
  logic   vld_q, vld_d;
  bblc_pkg::dp_cmd_t c;

  logic busy_out;
  assign busy_out = vld_q && !rsp_ready_i;
  assign req_ready_o = (state_q == S_IDLE) && !busy_out;
  assign rsp_valid_o = vld_q;
  assign cmd_o = c;

  always_comb begin
    c = '0;
    state_d = state_q;
    vld_d = vld_q && !rsp_ready_i;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i && req_ready_o) begin
          c.latch = 1'b1;
          c.scan_clr = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) state_d = S_DECIDE;
        else c.scan_step = 1'b1;
      end
      S_DECIDE: begin
        if (!busy_out) begin
          state_d = S_IDLE;
          c.last = 1'b1;
          c.emit = 1'b1;
          vld_d = 1'b1;
          case (bblc_pkg::cmd_e'(sts_i.command))
            bblc_pkg::CMD_ACCESS: begin
              if (sts_i.found) begin
                c.status = bblc_pkg::ST_HIT;
                c.hit_touch = 1'b1;
              end else if (!sts_i.load_ok) begin
                c.status = bblc_pkg::ST_FAILED;
              end else if (sts_i.empty || sts_i.fits) begin
                c.status = bblc_pkg::ST_LOADED;
                c.insert = 1'b1;
              end else begin
                c.emit = 1'b0;
                c.last = 1'b0;
                vld_d = vld_q && !rsp_ready_i;
                c.scan_clr = 1'b1;
                state_d = S_OLDSCAN;
              end
            end
            bblc_pkg::CMD_EVICT: begin
              if (sts_i.found) begin
                c.status = bblc_pkg::ST_REMOVED;
                c.evict_hit = 1'b1;
              end else c.status = bblc_pkg::ST_ABSENT;
            end
            bblc_pkg::CMD_CLEAR: begin
              c.status = bblc_pkg::ST_CLEARED;
              c.clear = 1'b1;
            end
            default: begin
              c.emit = 1'b0;
              vld_d = vld_q && !rsp_ready_i;
            end
          endcase
        end
      end
      S_OLDSCAN: begin
        if (sts_i.scan_done) state_d = S_VICTIM;
        else c.scan_step = 1'b1;
      end
      S_VICTIM: begin
        if (!busy_out) begin
          c.status = bblc_pkg::ST_VICTIM;
          c.emit = 1'b1;
          c.evict_old = 1'b1;
          vld_d = 1'b1;
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        // re-check fit after the eviction settles
        c.scan_clr = 1'b1;
        state_d = S_DECIDE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
    end
  end

endmodule

// ===== hw/rtl/byte_budget_lru_cache_directory.sv =====
// Directory of a byte-budgeted LRU cache with 16 entries. A request is
// taken when idle; it first scans all entries one per cycle for the key,
// then answers. A miss that must make room runs one more oldest-entry
// scan per victim. Each victim is its own response with last low; the
// final response has last high. The budget register is written through
// the config channel; the user must write it only while idle, as the
// block itself does not enforce it.
module byte_budget_lru_cache_directory (
  input  logic clk_i,
  input  logic rst_ni,
  bblc_req_if.sink   req,
  bblc_rsp_if.source rsp,
  bblc_cfg_if.sink   cfg
);

  logic [31:0] budget_q;
  bblc_pkg::dp_cmd_t cmd;
  bblc_pkg::dp_sts_t sts;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) budget_q <= bblc_pkg::BudgetReset;
    else if (cfg.valid) budget_q <= cfg.payload;
  end

  bblc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .rsp_valid_o (rsp.valid),
    .rsp_ready_i (rsp.ready),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  bblc_datapath u_dp (
    .clk_i, .rst_ni,
    .req_i (req.payload),
    .budget_i (budget_q),
    .cmd_i (cmd),
    .sts_o (sts),
    .rsp_o (rsp.payload)
  );

endmodule

// ===== hw/rtl/bblc_checker.sv =====
`include "assert_macros.svh"

module bblc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [2:0] rsp_status_i,
  input logic       rsp_last_i,
  input logic [8:0] rsp_count_i
);
  `CHK_NEXT(a_stall_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i,
    "rsp dropped")
  `CHK_IMPL(a_victim_notlast, clk_i, rst_ni,
    rsp_valid_i && rsp_status_i == bblc_pkg::ST_VICTIM, !rsp_last_i, "victim last")
  `CHK_IMPL(a_count_max, clk_i, rst_ni, rsp_valid_i,
    rsp_count_i <= 9'(bblc_pkg::Entries), "count overflow")
  `CHK_IMPL(a_clear_empty, clk_i, rst_ni,
    rsp_valid_i && rsp_status_i == bblc_pkg::ST_CLEARED, rsp_count_i == 9'd0,
    "clear left entries")
  `CHK_NEXT(a_no_accept_busy, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i,
    "accept twice")
endmodule

bind byte_budget_lru_cache_directory bblc_checker u_chk (
  .clk_i, .rst_ni,
  .req_valid_i (req.valid), .req_ready_i (req.ready),
  .rsp_valid_i (rsp.valid), .rsp_ready_i (rsp.ready),
  .rsp_status_i (rsp.payload.status), .rsp_last_i (rsp.payload.last),
  .rsp_count_i (rsp.payload.entry_count)
);

// ===== test/byte_budget_lru_cache_directory_tb.sv =====
`timescale 1ns / 1ps

module byte_budget_lru_cache_directory_tb;

  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainCycles = 400;
  localparam int unsigned StallLimit = 6000;

  // Shadow copy of the directory; predicts responses and checks them in order.
  class cache_shadow;
    logic [31:0]    keys[bblc_pkg::Entries];
    bit             vld[bblc_pkg::Entries];
    logic [31:0]    sizes[bblc_pkg::Entries];
    logic [63:0]    stamps[bblc_pkg::Entries];
    logic [36:0]    total_bytes;
    logic [63:0]    use_ctr;
    logic [31:0]    budget;
    bblc_pkg::rsp_t expected_rsps[$];
    int             errors;
    int             rsp_count;
    int             victims;
    int             hits;

    function new();
      foreach (vld[i]) vld[i] = 0;
      total_bytes = '0;
      use_ctr = '0;
      budget = bblc_pkg::BudgetReset;
      errors = 0;
      rsp_count = 0;
      victims = 0;
      hits = 0;
    endfunction

    function int unsigned live_count();
      int unsigned n;
      n = 0;
      foreach (vld[i]) if (vld[i]) n++;
      return n;
    endfunction

    function void push(bblc_pkg::status_e st, logic [31:0] k, logic [31:0] sz, logic rng,
                       logic lst);
      bblc_pkg::rsp_t e;
      e.status = st;
      e.key_out = k;
      e.object_size = sz;
      e.in_range = rng;
      e.bytes_in_use = total_bytes;
      e.entry_count = 9'(live_count());
      e.last = lst;
      expected_rsps.push_back(e);
    endfunction

    function logic span_fits(logic [31:0] off, logic [31:0] len, logic [31:0] sz);
      return ({1'b0, off} + {1'b0, len}) <= {1'b0, sz};
    endfunction

    function int lookup(logic [31:0] k);
      foreach (vld[i]) if (vld[i] && keys[i] == k) return i;
      return -1;
    endfunction

    function void note_request(bblc_pkg::req_t r);
      int slot;
      int oldest;
      int unsigned n;
      slot = lookup(r.key);
      case (bblc_pkg::cmd_e'(r.command))
        bblc_pkg::CMD_ACCESS: begin
          if (slot >= 0) begin
            use_ctr++;
            stamps[slot] = use_ctr;
            hits++;
            push(bblc_pkg::ST_HIT, r.key, sizes[slot],
                 span_fits(r.offset, r.length, sizes[slot]), 1'b1);
          end else if (!r.load_ok) begin
            push(bblc_pkg::ST_FAILED, r.key, '0, 1'b0, 1'b1);
          end else begin
            forever begin
              n = live_count();
              if (n == 0) break;
              if (total_bytes + 37'(r.load_size) <= 37'(budget) && n < bblc_pkg::Entries)
                break;
              oldest = -1;
              foreach (vld[i])
                if (vld[i] && (oldest < 0 || stamps[i] < stamps[oldest])) oldest = i;
              vld[oldest] = 0;
              total_bytes = total_bytes - 37'(sizes[oldest]);
              victims++;
              push(bblc_pkg::ST_VICTIM, keys[oldest], sizes[oldest], 1'b0, 1'b0);
            end
            slot = 0;
            for (int i = bblc_pkg::Entries - 1; i >= 0; i--) if (!vld[i]) slot = i;
            use_ctr++;
            vld[slot] = 1;
            keys[slot] = r.key;
            sizes[slot] = r.load_size;
            stamps[slot] = use_ctr;
            total_bytes = total_bytes + 37'(r.load_size);
            push(bblc_pkg::ST_LOADED, r.key, r.load_size,
                 span_fits(r.offset, r.length, r.load_size), 1'b1);
          end
        end
        bblc_pkg::CMD_EVICT: begin
          if (slot >= 0) begin
            vld[slot] = 0;
            total_bytes = total_bytes - 37'(sizes[slot]);
            push(bblc_pkg::ST_REMOVED, r.key, sizes[slot], 1'b0, 1'b1);
          end else begin
            push(bblc_pkg::ST_ABSENT, r.key, '0, 1'b0, 1'b1);
          end
        end
        bblc_pkg::CMD_CLEAR: begin
          foreach (vld[i]) vld[i] = 0;
          total_bytes = '0;
          push(bblc_pkg::ST_CLEARED, '0, '0, 1'b0, 1'b1);
        end
        default: ;
      endcase
    endfunction

    function void check_response(bblc_pkg::rsp_t a);
      bblc_pkg::rsp_t e;
      rsp_count++;
      if (expected_rsps.size() == 0) begin
        $error("unexpected response: status %0d key %0h", a.status, a.key_out);
        errors++;
        return;
      end
      e = expected_rsps.pop_front();
      if (a.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, a.status);
        errors++;
      end
      if (a.key_out !== e.key_out) begin
        $error("key_out: expected %0h, got %0h", e.key_out, a.key_out);
        errors++;
      end
      if (a.object_size !== e.object_size) begin
        $error("object_size: expected %0h, got %0h", e.object_size, a.object_size);
        errors++;
      end
      if (a.in_range !== e.in_range) begin
        $error("in_range: expected %0b, got %0b", e.in_range, a.in_range);
        errors++;
      end
      if (a.bytes_in_use !== e.bytes_in_use) begin
        $error("bytes_in_use: expected %0h, got %0h", e.bytes_in_use, a.bytes_in_use);
        errors++;
      end
      if (a.entry_count !== e.entry_count) begin
        $error("entry_count: expected %0d, got %0d", e.entry_count, a.entry_count);
        errors++;
      end
      if (a.last !== e.last) begin
        $error("last: expected %0b, got %0b", e.last, a.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  bblc_req_if req_if ();
  bblc_rsp_if rsp_if ();
  bblc_cfg_if cfg_if ();

  byte_budget_lru_cache_directory dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_if),
    .rsp    (rsp_if),
    .cfg    (cfg_if)
  );

  always #10 clk_i = ~clk_i;

  cache_shadow shadow = new();
  int unsigned progress = 0;
  int unsigned sent = 0;
  int unsigned cfg_writes = 0;
  bit hold_rx = 0;

  initial begin
    rst_ni <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.payload <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.payload <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Response side: random back-pressure plus an occasional long hold.
  initial begin
    int unsigned gap_left;
    int unsigned hold_left;
    gap_left = 0;
    hold_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) begin
        shadow.check_response(rsp_if.payload);
        progress++;
      end
      if (hold_rx) begin
        hold_rx = 0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        case ($urandom_range(0, 19))
          0, 1, 2: gap_left = $urandom_range(1, 3);
          3: gap_left = $urandom_range(15, 60);
          default: gap_left = 0;
        endcase
      end
    end
  end

  int unsigned idle_cycles = 0;
  int unsigned seen_progress = 0;
  always @(posedge clk_i) begin
    if (progress != seen_progress) begin
      seen_progress <= progress;
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_request(bblc_pkg::req_t r, int unsigned gap);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.payload <= r;
    do @(posedge clk_i); while (!req_if.ready);
    shadow.note_request(r);
    if (bblc_pkg::cmd_e'(r.command) != bblc_pkg::CMD_NONE) sent++;
    progress++;
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (shadow.expected_rsps.size() != 0) @(posedge clk_i);
  endtask

  // Budget writes only when idle; the extra wait covers a trailing ignored command.
  task automatic write_budget(logic [31:0] v);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.payload <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    shadow.budget = v;
    cfg_writes++;
    progress++;
  endtask

  function automatic bblc_pkg::req_t make_req(bblc_pkg::cmd_e c, logic [31:0] k,
                                              logic [31:0] off, logic [31:0] len,
                                              logic [31:0] sz, logic ok);
    bblc_pkg::req_t r;
    r.command = c;
    r.key = k;
    r.offset = off;
    r.length = len;
    r.load_size = sz;
    r.load_ok = ok;
    return r;
  endfunction

  function automatic logic [31:0] pick_span(logic [31:0] sz);
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $urandom_range(0, (sz >> 1) + 1);
  endfunction

  function automatic bblc_pkg::req_t random_req(logic [31:0] budget);
    bblc_pkg::req_t r;
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 75) r.command = bblc_pkg::CMD_ACCESS;
    else if (p < 90) r.command = bblc_pkg::CMD_EVICT;
    else if (p < 95) r.command = bblc_pkg::CMD_CLEAR;
    else r.command = bblc_pkg::CMD_NONE;
    r.key = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 23);
    case ($urandom_range(0, 9))
      0: r.load_size = $urandom;
      1: r.load_size = $urandom_range(0, budget);
      default: r.load_size = $urandom_range(0, budget / 6);
    endcase
    r.offset = pick_span(r.load_size);
    r.length = pick_span(r.load_size);
    r.load_ok = ($urandom_range(0, 6) != 0);
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    case ($urandom_range(0, 19))
      0, 1, 2, 3: return $urandom_range(1, 4);
      5: return $urandom_range(20, 80);
      default: return 0;
    endcase
  endfunction

  initial begin
    logic [31:0] budgets[5];
    bblc_pkg::req_t r;
    budgets = '{bblc_pkg::BudgetReset, 32'd1000, 32'd1, 32'hFFFF_FFFF, 32'd5000};
    @(posedge clk_i);
    while (rst_ni !== 1'b1) @(posedge clk_i);

    // directed: miss paths, hits, exact-span edge, evict/clear, ignored command
    send_request(make_req(bblc_pkg::CMD_ACCESS, 32'h0, '0, '0, '0, 1'b0), 0);
    send_request(make_req(bblc_pkg::CMD_ACCESS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1,
                          32'hFFFF_FFFF, 1'b1), 0);
    send_request(make_req(bblc_pkg::CMD_ACCESS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0,
                          1'b0), 0);
    send_request(make_req(bblc_pkg::CMD_ACCESS, 32'h1, 32'd10, 32'd90, 32'd100, 1'b1), 0);
    send_request(make_req(bblc_pkg::CMD_ACCESS, 32'h1, 32'd10, 32'd91, '0, 1'b1), 0);
    send_request(make_req(bblc_pkg::CMD_EVICT, 32'h1, '0, '0, '0, 1'b0), 0);
    send_request(make_req(bblc_pkg::CMD_EVICT, 32'h1, '0, '0, '0, 1'b0), 0);
    send_request(make_req(bblc_pkg::CMD_NONE, 32'h5, '0, '0, '0, 1'b1), 0);
    // seventeen distinct keys: table full forces an LRU victim
    for (int i = 0; i < 17; i++)
      send_request(make_req(bblc_pkg::CMD_ACCESS, 32'(100 + i), '0, 32'd4, 32'd8, 1'b1), 0);
    send_request(make_req(bblc_pkg::CMD_CLEAR, '0, '0, '0, '0, 1'b0), 0);

    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) write_budget(budgets[ph]);
      if (ph == 1) begin
        hold_rx = 1;
        for (int i = 0; i < 30; i++) send_request(random_req(budgets[ph]), 0);
      end
      for (int i = 0; i < 85; i++) begin
        if (i == 40) wait_drained();
        r = random_req(budgets[ph]);
        send_request(r, (ph == 3 && i < 30) ? 0 : pick_gap());
      end
    end
    write_budget(32'd1);
    for (int i = 0; i < 10; i++) send_request(random_req(32'd4), pick_gap());

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    $display("sent %0d requests, %0d budget writes, %0d responses checked",
             sent, cfg_writes, shadow.rsp_count);
    $display("hits %0d, lru victims %0d", shadow.hits, shadow.victims);
    if (shadow.errors == 0 && shadow.expected_rsps.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
